### rtl/mei_pkg.sv
`default_nettype none
package mei_pkg;

	localparam int FRAC_BITS = 60;
	localparam int ITER_BITS = 16;
	localparam int MAG_FRAC  = FRAC_BITS - 4;
	localparam int SQ_SHIFT  = FRAC_BITS + 4;

	localparam logic [63:0] MAG_ONE  = 64'd1 << MAG_FRAC;
	localparam logic [63:0] CARD_LIM = (64'd3 << MAG_FRAC) / 32;
	localparam logic [63:0] BULB_LIM = MAG_ONE / 16;
	localparam logic [63:0] Z_ONE    = 64'd1 << FRAC_BITS;
	localparam logic [63:0] INT_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] INT_MIN  = 64'h8000_0000_0000_0000;

	localparam logic [63:0] ITER_MASK = (64'd1 << ITER_BITS) - 64'd1;

	localparam logic [ITER_BITS-1:0] RST_MAX_ITER = ITER_BITS'(4096);
	localparam logic [63:0]          RST_RADIUS   = 64'd1 << 60;

	localparam logic [1:0] CFG_MAX_ITER = 2'd0;
	localparam logic [1:0] CFG_RADIUS   = 2'd1;
	localparam logic [1:0] CFG_PERIOD   = 2'd2;

	localparam logic [1:0] REASON_ESCAPED = 2'd0;
	localparam logic [1:0] REASON_LIMIT   = 2'd1;
	localparam logic [1:0] REASON_INSIDE  = 2'd2;
	localparam logic [1:0] REASON_PERIOD  = 2'd3;

	typedef enum logic [2:0] {
		OP_CR_CR,
		OP_CI_CI,
		OP_S_S,
		OP_XP_XP,
		OP_ZR_ZR,
		OP_ZI_ZI,
		OP_ZR_ZI
	} mul_op_t;

	typedef enum logic [1:0] {
		CAP_NONE,
		CAP_A,
		CAP_B,
		CAP_C
	} cap_t;

	typedef struct packed {
		logic    load_c;
		logic    mul_start;
		mul_op_t mul_op;
		cap_t    cap;
		logic    sc_sum;
		logic    set_inside;
		logic    upd1;
		logic    upd2;
		logic    out_load;
	} mei_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic s_lt_one;
		logic cr_neg;
		logic card_in;
		logic bulb_in;
		logic stop;
	} mei_sts_t;

	// x >> s, saturated to 64 bits
	function automatic logic [63:0] shr_sat(input logic [127:0] x, input int unsigned s);
		logic [127:0] r;
		r = x >> s;
		return (r[127:64] != 64'd0) ? '1 : r[63:0];
	endfunction

	function automatic logic [63:0] cap_pos(input logic [63:0] v);
		return v[63] ? INT_MAX : v;
	endfunction

	function automatic logic [63:0] abs64(input logic [63:0] a);
		return a[63] ? (64'd0 - a) : a;
	endfunction

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? INT_MIN : INT_MAX;
		return s[63:0];
	endfunction

endpackage
`default_nettype wire

### rtl/mei_if.sv
`default_nettype none
interface mei_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] c_real;
	logic [63:0] c_imag;

	modport source(output valid, output c_real, output c_imag, input ready);
	modport sink(input valid, input c_real, input c_imag, output ready);
endinterface

interface mei_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  exit_reason;
	logic [15:0] escape_count;
	logic [63:0] final_magnitude_sq;

	modport source(output valid, output exit_reason, output escape_count,
		output final_magnitude_sq, input ready);
	modport sink(input valid, input exit_reason, input escape_count,
		input final_magnitude_sq, output ready);
endinterface
`default_nettype wire

### rtl/mei_wmul.sv
`default_nettype none
// 64x64 unsigned product from four 32x32 partial products, one per cycle
module mei_wmul
	import mei_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [63:0]  a,
	input  wire logic [63:0]  b,
	output logic              done,
	output logic [127:0]      prod
);

	logic [63:0]  a_q, b_q, pp_q;
	logic [2:0]   cnt_q;
	logic [1:0]   sh_q;
	logic         busy_q, pv_q, done_q;
	logic [127:0] acc_q, pp_sh;
	logic [31:0]  opa, opb;

	assign opa = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign opb = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (sh_q)
			2'd0:    pp_sh = {64'd0, pp_q};
			2'd1:    pp_sh = {32'd0, pp_q, 32'd0};
			default: pp_sh = {pp_q, 64'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pv_q   <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				pv_q   <= 1'b0;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					pv_q   <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
					pv_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (pv_q) begin
			acc_q <= acc_q + pp_sh;
		end
		if (busy_q && cnt_q != 3'd4) begin
			pp_q <= opa * opb;
			sh_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

### rtl/mei_datapath.sv
`default_nettype none
module mei_datapath
	import mei_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mei_cmd_t cmd,
	output mei_sts_t      sts,
	input  wire logic     cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic [63:0] c_real,
	input  wire logic [63:0] c_imag,
	output logic [1:0]    exit_reason,
	output logic [15:0]   escape_count,
	output logic [63:0]   final_magnitude_sq
);

	logic [ITER_BITS-1:0] max_q, iter_q;
	logic [63:0]  radius_q;
	logic         pen_q;
	logic [63:0]  cr_q, ci_q, zr_q, zi_q, sr_q, si_q, s_q;
	logic [63:0]  dist_q, sqr_q, sqi_q, cross_q;
	logic [127:0] pa_q, pb_q, pc_q;
	logic [1:0]   why_q;

	logic [63:0]  mul_a, mul_b, xp, cfg_iter, cnt_full;
	logic         mul_done;
	logic [127:0] prod;

	assign xp = cr_q + Z_ONE;

	always_comb begin
		case (cmd.mul_op)
			OP_CR_CR: begin mul_a = abs64(cr_q); mul_b = abs64(cr_q); end
			OP_CI_CI: begin mul_a = abs64(ci_q); mul_b = abs64(ci_q); end
			OP_S_S:   begin mul_a = s_q;         mul_b = s_q;         end
			OP_XP_XP: begin mul_a = abs64(xp);   mul_b = abs64(xp);   end
			OP_ZR_ZR: begin mul_a = abs64(zr_q); mul_b = abs64(zr_q); end
			OP_ZI_ZI: begin mul_a = abs64(zi_q); mul_b = abs64(zi_q); end
			default:  begin mul_a = abs64(zr_q); mul_b = abs64(zi_q); end
		endcase
	end

	mei_wmul u_wmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	// cardioid: 8*s*s - 3*s + c_real < 3/32
	logic [63:0] s2, crd16, card_v, bulb_v;
	assign s2     = shr_sat(pc_q, MAG_FRAC);
	assign crd16  = 64'($signed(cr_q + (cr_q[63] ? 64'd15 : 64'd0)) >>> 4);
	assign card_v = (s2 << 3) - (s_q + (s_q << 1)) + crd16;
	assign bulb_v = shr_sat(pc_q + pb_q, SQ_SHIFT);

	// iteration update
	logic [63:0] cp, cross_n, diff, zr_n, zi_n;
	logic [ITER_BITS-1:0] iter_dec;
	logic stop, moment, rep;

	assign cp      = cap_pos(shr_sat(pc_q, FRAC_BITS - 1));
	assign cross_n = (zr_q[63] != zi_q[63]) ? (64'd0 - cp) : cp;
	assign diff    = sqr_q - sqi_q;
	assign zr_n    = sat_add(cr_q, diff);
	assign zi_n    = sat_add(ci_q, cross_q);
	assign stop    = (iter_q == '0) || (dist_q >= radius_q);
	assign iter_dec = stop ? iter_q : iter_q - ITER_BITS'(1);
	assign moment  = (iter_dec & (iter_dec - ITER_BITS'(1))) == '0;
	assign rep     = (zr_n == sr_q) && (zi_n == si_q);

	assign sts.mul_done = mul_done;
	assign sts.s_lt_one = s_q < MAG_ONE;
	assign sts.cr_neg   = cr_q[63];
	assign sts.card_in  = $signed(card_v) < $signed(CARD_LIM);
	assign sts.bulb_in  = bulb_v < BULB_LIM;
	assign sts.stop     = stop;

	assign cfg_iter = cfg_data & 64'hFFFF & ITER_MASK;
	assign cnt_full = 64'(max_q - iter_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= RST_MAX_ITER;
			radius_q <= RST_RADIUS;
			pen_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_ITER: max_q    <= cfg_iter[ITER_BITS-1:0];
				CFG_RADIUS:   radius_q <= cfg_data;
				CFG_PERIOD:   pen_q    <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_c) begin
			cr_q   <= c_real;
			ci_q   <= c_imag;
			zr_q   <= c_real;
			zi_q   <= c_imag;
			sr_q   <= c_real;
			si_q   <= c_imag;
			iter_q <= max_q;
			why_q  <= REASON_LIMIT;
		end
		if (mul_done) begin
			case (cmd.cap)
				CAP_A:   pa_q <= prod;
				CAP_B:   pb_q <= prod;
				CAP_C:   pc_q <= prod;
				default: ;
			endcase
		end
		if (cmd.sc_sum)
			s_q <= shr_sat(pa_q + pb_q, SQ_SHIFT);
		if (cmd.set_inside) begin
			iter_q <= '0;
			why_q  <= REASON_INSIDE;
		end
		if (cmd.upd1) begin
			dist_q  <= shr_sat(pa_q + pb_q, SQ_SHIFT);
			sqr_q   <= cap_pos(shr_sat(pa_q, FRAC_BITS));
			sqi_q   <= cap_pos(shr_sat(pb_q, FRAC_BITS));
			cross_q <= cross_n;
		end
		if (cmd.upd2) begin
			zr_q <= zr_n;
			zi_q <= zi_n;
			if (pen_q) begin
				if (rep) begin
					if (iter_dec != '0)
						why_q <= REASON_PERIOD;
					iter_q <= '0;
				end else begin
					iter_q <= iter_dec;
				end
				if (moment) begin
					sr_q <= zr_n;
					si_q <= zi_n;
				end
			end else begin
				iter_q <= iter_dec;
			end
		end
		if (cmd.out_load) begin
			final_magnitude_sq <= dist_q;
			if (iter_q != '0) begin
				exit_reason  <= REASON_ESCAPED;
				escape_count <= cnt_full[15:0];
			end else begin
				exit_reason  <= why_q;
				escape_count <= 16'd0;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/mei_ctrl.sv
`default_nettype none
module mei_ctrl
	import mei_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire mei_sts_t sts,
	output mei_cmd_t      cmd
);

	typedef enum logic [20:0] {
		S_IDLE    = 21'h000001,
		S_SCX_GO  = 21'h000002,
		S_SCX_WT  = 21'h000004,
		S_SCY_GO  = 21'h000008,
		S_SCY_WT  = 21'h000010,
		S_SC_SUM  = 21'h000020,
		S_SCS_GO  = 21'h000040,
		S_SCS_WT  = 21'h000080,
		S_SC_CARD = 21'h000100,
		S_SCB_GO  = 21'h000200,
		S_SCB_WT  = 21'h000400,
		S_SC_BULB = 21'h000800,
		S_ITR_GO  = 21'h001000,
		S_ITR_WT  = 21'h002000,
		S_ITI_GO  = 21'h004000,
		S_ITI_WT  = 21'h008000,
		S_ITX_GO  = 21'h010000,
		S_ITX_WT  = 21'h020000,
		S_UPD1    = 21'h040000,
		S_UPD2    = 21'h080000,
		S_DONE    = 21'h100000
	} state_t;

	state_t state_q, state_n;
	logic   ov_q;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		cmd.mul_op = OP_CR_CR;
		cmd.cap    = CAP_NONE;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_c = in_valid;
				if (in_valid)
					state_n = S_SCX_GO;
			end
			S_SCX_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = OP_CR_CR;
				state_n       = S_SCX_WT;
			end
			S_SCX_WT: begin
				cmd.cap = CAP_A;
				if (sts.mul_done)
					state_n = S_SCY_GO;
			end
			S_SCY_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = OP_CI_CI;
				state_n       = S_SCY_WT;
			end
			S_SCY_WT: begin
				cmd.cap = CAP_B;
				if (sts.mul_done)
					state_n = S_SC_SUM;
			end
			S_SC_SUM: begin
				cmd.sc_sum = 1'b1;
				state_n    = S_SCS_GO;
			end
			S_SCS_GO: begin
				// s is now valid
				if (sts.s_lt_one) begin
					cmd.mul_start = 1'b1;
					cmd.mul_op    = OP_S_S;
					state_n       = S_SCS_WT;
				end else if (sts.cr_neg) begin
					state_n = S_SCB_GO;
				end else begin
					state_n = S_ITR_GO;
				end
			end
			S_SCS_WT: begin
				cmd.cap = CAP_C;
				if (sts.mul_done)
					state_n = S_SC_CARD;
			end
			S_SC_CARD: begin
				cmd.set_inside = sts.card_in;
				if (sts.card_in || !sts.cr_neg)
					state_n = S_ITR_GO;
				else
					state_n = S_SCB_GO;
			end
			S_SCB_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = OP_XP_XP;
				state_n       = S_SCB_WT;
			end
			S_SCB_WT: begin
				cmd.cap = CAP_C;
				if (sts.mul_done)
					state_n = S_SC_BULB;
			end
			S_SC_BULB: begin
				cmd.set_inside = sts.bulb_in;
				state_n        = S_ITR_GO;
			end
			S_ITR_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = OP_ZR_ZR;
				state_n       = S_ITR_WT;
			end
			S_ITR_WT: begin
				cmd.cap = CAP_A;
				if (sts.mul_done)
					state_n = S_ITI_GO;
			end
			S_ITI_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = OP_ZI_ZI;
				state_n       = S_ITI_WT;
			end
			S_ITI_WT: begin
				cmd.cap = CAP_B;
				if (sts.mul_done)
					state_n = S_ITX_GO;
			end
			S_ITX_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = OP_ZR_ZI;
				state_n       = S_ITX_WT;
			end
			S_ITX_WT: begin
				cmd.cap = CAP_C;
				if (sts.mul_done)
					state_n = S_UPD1;
			end
			S_UPD1: begin
				cmd.upd1 = 1'b1;
				state_n  = S_UPD2;
			end
			S_UPD2: begin
				cmd.upd2 = 1'b1;
				state_n  = sts.stop ? S_DONE : S_ITR_GO;
			end
			S_DONE: begin
				if (!ov_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;

endmodule
`default_nettype wire

### rtl/mandelbrot_escape_iteration_top.sv
`default_nettype none
// channel   dir  payload                                          handshake
// points    in   c_real[64], c_imag[64]                           valid/ready
// results   out  exit_reason[2], escape_count[16],                valid/ready
//                final_magnitude_sq[64]
// cfg       in   cfg_index[2], cfg_data[64]                       cfg_we
//
// One point at a time. Shortcut tests run first, then each orbit pass
// runs three 64x64 squares/products on one shared 32x32 multiplier
// (a start state and a wait state each) plus the update states UPD1 and
// UPD2. After the last pass the point's result is loaded into the result
// register from S_DONE.
// arst_n clears control; a finished result waits in the output register
// while the next point is accepted, and the block stalls only at completion.
module mandelbrot_escape_iteration_top
	import mei_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	mei_in_if.sink           points,
	mei_out_if.source        results,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	mei_cmd_t cmd;
	mei_sts_t sts;

	mei_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (points.valid),
		.in_ready  (points.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mei_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.c_real             (points.c_real),
		.c_imag             (points.c_imag),
		.exit_reason        (results.exit_reason),
		.escape_count       (results.escape_count),
		.final_magnitude_sq (results.final_magnitude_sq)
	);

endmodule
`default_nettype wire
